/* rtl/mcsp_pkg.sv */
// Shared constants, command codes and register indexes of the servo pulse generator.
package mcsp_pkg;

	localparam int unsigned DEF_CHANNELS = 16;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CHAN_W  = 4;
	localparam int unsigned PULSE_W = 15;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned PINS_W  = 16;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START = 2'd2;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;

	localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd500;
	localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd2500;
	localparam logic [PULSE_W-1:0] PERIOD_RST    = 15'd20000;

endpackage

/* rtl/multi_channel_servo_pwm.sv */
// Top level of the multi-channel servo pulse generator with double-buffered widths.
//
// Usage:
//   The s_ stream carries requests: s_tuser holds the command (write preload width,
//   half-microsecond tick, start), s_tdata the channel and the requested width.
//   Every request yields exactly one result on the m_ stream: the pin levels of
//   channels 0..15 plus the period_start, all_low and running flags.
//   The cfg channel writes min_pulse, max_pulse and period; write it only while idle.
//   A taken request's result is registered and appears in the cycle after it. The block
//   takes one request per clock while the receiver keeps up; the per-channel width
//   comparators settle all pins combinationally between the held state and the result register.
//   When the receiver stalls, the result register holds its value and s_tready drops
//   until the result is taken; a request is taken in the same cycle the old result
//   leaves, so no bubble is inserted.
//   Reset (arst_n low) clears both width banks, the tick counter, all pins, the
//   update flag and running, and loads the default register values.
module multi_channel_servo_pwm #(
	parameter int unsigned CHANNELS = mcsp_pkg::DEF_CHANNELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mcsp_pkg::IN_DATA_W-1:0]     s_tdata,  // [3:0] channel, [18:4] width, rest 0
	input  logic [mcsp_pkg::CMD_W-1:0]         s_tuser,  // [1:0] command
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] pins, [16] period_start, [17] all_low, [18] running, rest 0
	output logic [mcsp_pkg::OUT_DATA_W-1:0]    m_tdata,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mcsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcsp_pkg::PULSE_W-1:0]       cfg_data
);

	localparam int unsigned EXT_W = (CHANNELS > mcsp_pkg::PINS_W) ? CHANNELS : mcsp_pkg::PINS_W;

	// Configuration registers
	logic [mcsp_pkg::PULSE_W-1:0] min_pulse_q, max_pulse_q, period_q;

	// Generator state
	logic [mcsp_pkg::PULSE_W-1:0] preload_q [CHANNELS];
	logic [mcsp_pkg::PULSE_W-1:0] active_q  [CHANNELS];
	logic [mcsp_pkg::TICK_W-1:0]  tick_q;
	logic [CHANNELS-1:0]          pins_q;
	logic                         updated_q;
	logic                         running_q;

	// Result register
	logic                             out_valid_q;
	logic [mcsp_pkg::OUT_DATA_W-1:0]  out_data_q;

	// Request fields
	logic [mcsp_pkg::CMD_W-1:0]   cmd;
	logic [mcsp_pkg::CHAN_W-1:0]  chan;
	logic [mcsp_pkg::PULSE_W-1:0] req_width;
	logic                         accept;

	// Next-state values
	logic [mcsp_pkg::PULSE_W-1:0] clamped;
	logic                         wr_en;
	logic                         take;
	logic [mcsp_pkg::TICK_W-1:0]  top;
	logic [mcsp_pkg::TICK_W-1:0]  tick_n;
	logic [CHANNELS-1:0]          pins_base;
	logic [CHANNELS-1:0]          pins_n;
	logic [CHANNELS-1:0]          hit;
	logic                         running_n;
	logic                         updated_n;
	logic                         pstart;
	logic                         alow;
	logic [EXT_W-1:0]             pins_ext;

	assign cmd       = s_tuser;
	assign chan      = s_tdata[3:0];
	assign req_width = s_tdata[18:4];

	// Take a request whenever the result slot is free or being emptied this cycle.
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Clamp: when the bounds cross, a width above the upper bound gets the upper bound and any other gets the lower.
	always_comb begin
		if (req_width > max_pulse_q) begin
			clamped = max_pulse_q;
		end else if (req_width < min_pulse_q) begin
			clamped = min_pulse_q;
		end else begin
			clamped = req_width;
		end
	end

	assign top = {period_q, 1'b0};

	always_comb begin
		wr_en     = 1'b0;
		take      = 1'b0;
		tick_n    = tick_q;
		pins_base = pins_q;
		pins_n    = pins_q;
		hit       = '0;
		running_n = running_q;
		pstart    = 1'b0;
		alow      = 1'b0;
		case (cmd)
			mcsp_pkg::CMD_WRITE: begin
				wr_en = (32'(chan) < 32'(CHANNELS));
			end
			mcsp_pkg::CMD_START: begin
				take      = updated_q;
				tick_n    = '0;
				pins_n    = '1;
				running_n = 1'b1;
				pstart    = 1'b1;
			end
			mcsp_pkg::CMD_TICK: begin
				if (running_q) begin
					// Wrap the counter once it reaches or passes twice the period.
					if (tick_q >= top) begin
						tick_n    = '0;
						pins_base = '1;
						pstart    = 1'b1;
					end else begin
						tick_n = 16'(tick_q + 16'd1);
					end
					// Drop each channel whose doubled width matches the new count.
					for (int k = 0; k < int'(CHANNELS); k++) begin
						hit[k] = ({active_q[k], 1'b0} == tick_n);
					end
					pins_n = pins_base & ~hit;
					alow   = (pins_base != '0) && (pins_n == '0);
					take   = alow && updated_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (wr_en) begin
			updated_n = 1'b1;
		end else if (take) begin
			updated_n = 1'b0;
		end else begin
			updated_n = updated_q;
		end
	end

	assign pins_ext = EXT_W'(pins_n);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= mcsp_pkg::MIN_PULSE_RST;
			max_pulse_q <= mcsp_pkg::MAX_PULSE_RST;
			period_q    <= mcsp_pkg::PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mcsp_pkg::REG_MIN_PULSE: min_pulse_q <= cfg_data;
				mcsp_pkg::REG_MAX_PULSE: max_pulse_q <= cfg_data;
				mcsp_pkg::REG_PERIOD:    period_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Generator state; both width banks reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < int'(CHANNELS); k++) begin
				preload_q[k] <= '0;
				active_q[k]  <= '0;
			end
			tick_q    <= '0;
			pins_q    <= '0;
			updated_q <= 1'b0;
			running_q <= 1'b0;
		end else if (accept) begin
			for (int k = 0; k < int'(CHANNELS); k++) begin
				if (wr_en && (32'(chan) == 32'(k))) begin
					preload_q[k] <= clamped;
				end
				if (take) begin
					active_q[k] <= preload_q[k];
				end
			end
			tick_q    <= tick_n;
			pins_q    <= pins_n;
			updated_q <= updated_n;
			running_q <= running_n;
		end
	end

	// Result register: load on accept, release when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'd0, running_n, alow, pstart, pins_ext[mcsp_pkg::PINS_W-1:0]};
		end
	end

endmodule
